[design/pbi_pkg.sv]
// Package for the periodic bilinear interpolator.
// Holds field widths, pipeline stage layout and the item function codes.
// No dependencies.
package pbi_pkg;

    localparam int COORD_W      = 32;
    localparam int VALUE_W      = 32;
    localparam int NUM_NBR      = 4;
    localparam int WRAP_STAGES  = 4;
    localparam int BLEND_STAGES = 4;
    localparam int STG_ADDR     = WRAP_STAGES;
    localparam int STG_RAM      = STG_ADDR + 1;
    localparam int NUM_STAGES   = STG_RAM + 1 + BLEND_STAGES;

    typedef enum logic
    {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

endpackage

[design/pbi_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/pbi_wrap.sv]
// Coordinate wrap pipeline: splits a fixed point coordinate into fraction and
// grid index modulo the grid size, and gives the upper neighbour index. Uses pbi_pkg.
module pbi_wrap #(
    parameter int GRID_SIZE = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic [pbi_pkg::WRAP_STAGES-1:0]     en,
    input  logic signed [pbi_pkg::COORD_W-1:0]  pos,
    output logic [$clog2(GRID_SIZE)-1:0]        idx_lo,
    output logic [$clog2(GRID_SIZE)-1:0]        idx_hi,
    output logic [FRAC_BITS-1:0]                frac,
    output logic [FRAC_BITS:0]                  frac_inv
);

    import pbi_pkg::*;

    localparam int IW  = $clog2(GRID_SIZE);
    localparam int IPW = COORD_W - FRAC_BITS;
    localparam int UW  = ((IPW > IW) ? IPW : IW) + 1;
    localparam int RW  = IW + 1;
    localparam logic [UW-1:0] OFFS =
        UW'(((2 ** (IPW - 1) + GRID_SIZE - 1) / GRID_SIZE) * GRID_SIZE);
    localparam logic [UW-1:0] RECIP = UW'((64'd1 << UW) / 64'(GRID_SIZE));
    localparam logic [RW-1:0] GSZ_R = RW'(GRID_SIZE);
    localparam logic [IW-1:0] LAST  = IW'(GRID_SIZE - 1);
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic signed [IPW-1:0] ip;
    logic [UW-1:0]         u_next;
    logic [2*UW-1:0]       prod;
    logic [RW-1:0]         qg;
    logic [RW-1:0]         r_next;
    logic [IW-1:0]         lo_next;
    logic [IW-1:0]         hi_next;

    logic [UW-1:0]         u1_reg;
    logic [UW-1:0]         q2_reg;
    logic [RW-1:0]         ulo2_reg;
    logic [RW-1:0]         r3_reg;
    logic [FRAC_BITS-1:0]  f1_reg;
    logic [FRAC_BITS-1:0]  f2_reg;
    logic [FRAC_BITS-1:0]  f3_reg;
    logic [FRAC_BITS-1:0]  f4_reg;
    logic [FRAC_BITS:0]    inv4_reg;
    logic [IW-1:0]         lo4_reg;
    logic [IW-1:0]         hi4_reg;

    // offset by a multiple of the grid size to keep the integer part non-negative
    assign ip     = pos[COORD_W-1:FRAC_BITS];
    assign u_next = UW'(ip) + OFFS;

    // quotient estimate by reciprocal, at most one short
    assign prod   = (2*UW)'(u1_reg) * (2*UW)'(RECIP);
    assign qg     = q2_reg[RW-1:0] * GSZ_R;
    assign r_next = ulo2_reg - qg;

    assign lo_next = (r3_reg >= GSZ_R) ? IW'(r3_reg - GSZ_R) : IW'(r3_reg);
    assign hi_next = (lo_next == LAST) ? '0 : lo_next + IW'(1);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            u1_reg <= u_next;
            f1_reg <= pos[FRAC_BITS-1:0];
        end
        if (en[1])
        begin
            q2_reg   <= prod[2*UW-1:UW];
            ulo2_reg <= u1_reg[RW-1:0];
            f2_reg   <= f1_reg;
        end
        if (en[2])
        begin
            r3_reg <= r_next;
            f3_reg <= f2_reg;
        end
        if (en[3])
        begin
            lo4_reg  <= lo_next;
            hi4_reg  <= hi_next;
            f4_reg   <= f3_reg;
            inv4_reg <= ONE - {1'b0, f3_reg};
        end
    end

    assign idx_lo   = lo4_reg;
    assign idx_hi   = hi4_reg;
    assign frac     = f4_reg;
    assign frac_inv = inv4_reg;

endmodule

[design/pbi_blend.sv]
// Blend pipeline: weights times the four neighbour samples as split partial
// products, summed in a registered tree, scaled down by truncation. Uses pbi_pkg.
module pbi_blend #(
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                               clk,
    input  logic [pbi_pkg::BLEND_STAGES-1:0]   en,
    input  logic signed [SAMPLE_WIDTH-1:0]     smp [pbi_pkg::NUM_NBR],
    input  logic [2*FRAC_BITS:0]               wgt [pbi_pkg::NUM_NBR],
    output logic [pbi_pkg::VALUE_W-1:0]        value
);

    import pbi_pkg::*;

    localparam int WW  = 2 * FRAC_BITS + 1;
    localparam int WL  = WW / 2;
    localparam int SW  = SAMPLE_WIDTH;
    localparam int SL  = SW / 2;
    localparam int PPW = (WW - WL) + (SW - SL) + 2;
    localparam int ACW = 2 * FRAC_BITS + VALUE_W;

    logic signed [PPW-1:0] pll_next [NUM_NBR];
    logic signed [PPW-1:0] plh_next [NUM_NBR];
    logic signed [PPW-1:0] phl_next [NUM_NBR];
    logic signed [PPW-1:0] phh_next [NUM_NBR];
    logic [ACW-1:0]        term_next [NUM_NBR];
    logic [ACW-1:0]        sum_next;

    logic signed [PPW-1:0] pll_reg [NUM_NBR];
    logic signed [PPW-1:0] plh_reg [NUM_NBR];
    logic signed [PPW-1:0] phl_reg [NUM_NBR];
    logic signed [PPW-1:0] phh_reg [NUM_NBR];
    logic [ACW-1:0]        term_reg [NUM_NBR];
    logic [ACW-1:0]        pair_reg [2];
    logic [VALUE_W-1:0]    value_reg;

    always_comb
    begin
        for (int n = 0; n < NUM_NBR; n++)
        begin
            pll_next[n] = $signed({1'b0, wgt[n][WL-1:0]}) * $signed({1'b0, smp[n][SL-1:0]});
            plh_next[n] = $signed({1'b0, wgt[n][WL-1:0]}) * $signed(smp[n][SW-1:SL]);
            phl_next[n] = $signed({1'b0, wgt[n][WW-1:WL]}) * $signed({1'b0, smp[n][SL-1:0]});
            phh_next[n] = $signed({1'b0, wgt[n][WW-1:WL]}) * $signed(smp[n][SW-1:SL]);
            term_next[n] = ACW'(pll_reg[n])
                         + (ACW'(plh_reg[n]) << SL)
                         + (ACW'(phl_reg[n]) << WL)
                         + (ACW'(phh_reg[n]) << (WL + SL));
        end
    end

    assign sum_next = pair_reg[0] + pair_reg[1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pll_reg <= pll_next;
            plh_reg <= plh_next;
            phl_reg <= phl_next;
            phh_reg <= phh_next;
        end
        if (en[1])
        begin
            term_reg <= term_next;
        end
        if (en[2])
        begin
            pair_reg[0] <= term_reg[0] + term_reg[1];
            pair_reg[1] <= term_reg[2] + term_reg[3];
        end
        if (en[3])
        begin
            value_reg <= sum_next[ACW-1 -: VALUE_W];
        end
    end

    assign value = value_reg;

endmodule

[design/periodic_bilinear_interpolator_top.sv]
// Periodic bilinear interpolator, top level: handshake control, address stage,
// grid RAM copies. Uses pbi_pkg, pbi_wrap, pbi_blend, pbi_ram.
//
// Usage:
//   Input channel item_valid / item_stall carries write items (func = 0:
//   write_value stored at grid[write_col][write_row], ignored when an index
//   is outside the grid) and query items (func = 1: x_pos, y_pos in fixed
//   point grid units, wrapped modulo the grid size). Each query gives one
//   item on result_valid / result_stall; writes give none.
//   Throughput: one item per clock while the receiver does not stall,
//   writes and queries mixed. Pipeline: ten register stages. Writes land
//   in the grid at the RAM stage, in item order with the queries around
//   them. The four neighbours are read together from four copies of the
//   grid RAM, each written by every write item whose indices are inside
//   the grid.
//   Reset clears the pipeline valid bits only; grid contents stay undefined
//   until written, so no clearing pass is needed.
//   A stalled receiver holds the output item; upstream stages keep filling
//   empty slots and item_stall rises only once every stage holds an item.
module periodic_bilinear_interpolator_top #(
    parameter int GRID_SIZE    = 256,
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               func,
    input  logic signed [pbi_pkg::COORD_W-1:0] x_pos,
    input  logic signed [pbi_pkg::COORD_W-1:0] y_pos,
    input  logic [7:0]                         write_col,
    input  logic [7:0]                         write_row,
    input  logic signed [31:0]                 write_value,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [pbi_pkg::VALUE_W-1:0] value
);

    import pbi_pkg::*;

    localparam int IW    = $clog2(GRID_SIZE);
    localparam int DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = 2 * FRAC_BITS + 1;
    localparam int SW    = SAMPLE_WIDTH;
    localparam logic [AW-1:0] G_A = AW'(GRID_SIZE);

    stage_vec_t vld_reg;
    stage_vec_t vld_next;
    stage_vec_t rdy;

    // side pipeline for write items, stages up to the address stage
    func_t          func_reg [STG_ADDR+1];
    logic           wok_reg  [STG_ADDR+1];
    logic [AW-1:0]  wadr_reg [STG_ADDR+1];
    logic [SW-1:0]  wval_reg [STG_ADDR+1];

    logic [IW-1:0]        x_lo, x_hi, y_lo, y_hi;
    logic [FRAC_BITS-1:0] fx, fy;
    logic [FRAC_BITS:0]   ix, iy;

    logic [AW-1:0]        rad_next [NUM_NBR];
    logic [WW-1:0]        wgt_next [NUM_NBR];
    logic [AW-1:0]        rad_reg  [NUM_NBR];
    logic [WW-1:0]        wgt4_reg [NUM_NBR];
    logic [WW-1:0]        wgt5_reg [NUM_NBR];
    logic signed [SW-1:0] smp      [NUM_NBR];

    logic           ram_we;
    logic           wok_next;
    logic [AW-1:0]  wadr_next;

    // ready chain: a stage takes a new item when empty or when it moves on
    always_comb
    begin
        rdy[NUM_STAGES-1] = ~vld_reg[NUM_STAGES-1] | ~result_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = ~vld_reg[k] | rdy[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = item_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (rdy[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
        // drop write items once they reach the grid
        if (rdy[STG_RAM])
        begin
            vld_next[STG_RAM] = vld_reg[STG_ADDR] && (func_reg[STG_ADDR] == FUNC_QUERY);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign item_stall   = ~rdy[0];
    assign result_valid = vld_reg[NUM_STAGES-1];

    assign wok_next  = (int'(write_col) < GRID_SIZE) && (int'(write_row) < GRID_SIZE);
    assign wadr_next = AW'(write_col) * G_A + AW'(write_row);

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            func_reg[0] <= func_t'(func);
            wok_reg[0]  <= wok_next;
            wadr_reg[0] <= wadr_next;
            wval_reg[0] <= SW'(write_value);
        end
        for (int k = 1; k <= STG_ADDR; k++)
        begin
            if (rdy[k])
            begin
                func_reg[k] <= func_reg[k-1];
                wok_reg[k]  <= wok_reg[k-1];
                wadr_reg[k] <= wadr_reg[k-1];
                wval_reg[k] <= wval_reg[k-1];
            end
        end
    end

    pbi_wrap #(
        .GRID_SIZE (GRID_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_wrap_x (
        .clk      (clk),
        .en       (rdy[WRAP_STAGES-1:0]),
        .pos      (x_pos),
        .idx_lo   (x_lo),
        .idx_hi   (x_hi),
        .frac     (fx),
        .frac_inv (ix)
    );

    pbi_wrap #(
        .GRID_SIZE (GRID_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_wrap_y (
        .clk      (clk),
        .en       (rdy[WRAP_STAGES-1:0]),
        .pos      (y_pos),
        .idx_lo   (y_lo),
        .idx_hi   (y_hi),
        .frac     (fy),
        .frac_inv (iy)
    );

    // neighbour order: (lo,lo), (hi,lo), (lo,hi), (hi,hi) in (x,y)
    always_comb
    begin
        rad_next[0] = AW'(x_lo) * G_A + AW'(y_lo);
        rad_next[1] = AW'(x_hi) * G_A + AW'(y_lo);
        rad_next[2] = AW'(x_lo) * G_A + AW'(y_hi);
        rad_next[3] = AW'(x_hi) * G_A + AW'(y_hi);
        wgt_next[0] = ix * iy;
        wgt_next[1] = fx * iy;
        wgt_next[2] = ix * fy;
        wgt_next[3] = fx * fy;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[STG_ADDR])
        begin
            rad_reg  <= rad_next;
            wgt4_reg <= wgt_next;
        end
        if (rdy[STG_RAM])
        begin
            wgt5_reg <= wgt4_reg;
        end
    end

    assign ram_we = rdy[STG_RAM] && vld_reg[STG_ADDR]
                 && (func_reg[STG_ADDR] == FUNC_WRITE) && wok_reg[STG_ADDR];

    for (genvar n = 0; n < NUM_NBR; n++)
    begin : g_grid
        pbi_ram #(
            .WIDTH (SW),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr (wadr_reg[STG_ADDR]),
            .wdata (wval_reg[STG_ADDR]),
            .re    (rdy[STG_RAM]),
            .raddr (rad_reg[n]),
            .rdata (smp[n])
        );
    end

    pbi_blend #(
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_blend (
        .clk   (clk),
        .en    (rdy[NUM_STAGES-1:STG_RAM+1]),
        .smp   (smp),
        .wgt   (wgt5_reg),
        .value (value)
    );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for periodic_bilinear_interpolator_top: grid writes and wrapped queries
// from a pending-item queue, randomly gapped and stalled; depends on pbi_pkg and the top level.
// Query values are predicted from a local grid copy and compared in order.
`timescale 1ns / 100ps

module tb_top;

    import pbi_pkg::*;

    localparam int GRID        = 256;
    localparam int FRAC        = 16;
    localparam longint ONE     = 64'sd1 << FRAC;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        func_t              func;
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic [7:0]         write_col;
        logic [7:0]         write_row;
        logic signed [31:0] write_value;
    } grid_item_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    func_t              func         = FUNC_WRITE;
    logic signed [31:0] x_pos        = '0;
    logic signed [31:0] y_pos        = '0;
    logic [7:0]         write_col    = '0;
    logic [7:0]         write_row    = '0;
    logic signed [31:0] write_value  = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [31:0] value;

    grid_item_t         pending_items[$];
    logic [31:0]        expected_values[$];
    logic [15:0]        block_origins[$];
    logic signed [31:0] grid_mem [0:GRID-1][0:GRID-1];
    grid_item_t         cur_item;
    int                 send_gap     = 0;
    bit                 send_steady  = 1'b0;
    int                 hold_left    = 0;
    bit                 recv_steady  = 1'b0;
    int                 error_count  = 0;
    int                 cycle_count  = 0;

    periodic_bilinear_interpolator_top u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .write_col    (write_col),
        .write_row    (write_row),
        .write_value  (write_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void split_coord(input logic signed [31:0] c, output int idx,
                                        output longint frac);
        longint s;
        longint ip;
        s    = c;
        frac = s & (ONE - 1);
        ip   = (s - frac) / ONE;
        idx  = int'(ip % GRID);
        if (idx < 0)
            idx += GRID;
    endfunction

    function automatic logic [31:0] interp_value(input logic signed [31:0] xq,
                                                 input logic signed [31:0] yq);
        int          x0, y0, x1, y1;
        longint      fx, fy, gx, gy, acc;
        logic [63:0] r;
        split_coord(xq, x0, fx);
        split_coord(yq, y0, fy);
        x1  = (x0 + 1) % GRID;
        y1  = (y0 + 1) % GRID;
        gx  = ONE - fx;
        gy  = ONE - fy;
        acc = gx * gy * longint'(grid_mem[x0][y0])
            + fx * gy * longint'(grid_mem[x1][y0])
            + gx * fy * longint'(grid_mem[x0][y1])
            + fx * fy * longint'(grid_mem[x1][y1]);
        r = acc >>> (2 * FRAC);
        return r[31:0];
    endfunction

    function automatic void accept_item(input grid_item_t it);
        if (it.func == FUNC_WRITE)
        begin
            if (it.write_col < GRID && it.write_row < GRID)
                grid_mem[it.write_col][it.write_row] = it.write_value;
        end
        else
            expected_values.insert(expected_values.size(), interp_value(it.x_pos, it.y_pos));
    endfunction

    function automatic logic [31:0] rand_sample();
        logic [31:0] extremes[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        if ($urandom_range(0, 7) == 0)
            return extremes[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    function automatic logic [31:0] coord_for(input int origin);
        int          k;
        int          ip;
        logic [15:0] frac;
        k  = int'($urandom_range(0, 255)) - 128;
        ip = origin + GRID * k;
        case ($urandom_range(0, 7))
            0:       frac = 16'h0000;
            1:       frac = 16'hFFFF;
            default: frac = 16'($urandom);
        endcase
        return {16'(ip), frac};
    endfunction

    task automatic push_write(input logic [7:0] col, input logic [7:0] row,
                              input logic [31:0] sample);
        grid_item_t it;
        it.func        = FUNC_WRITE;
        it.x_pos       = $urandom;
        it.y_pos       = $urandom;
        it.write_col   = col;
        it.write_row   = row;
        it.write_value = sample;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_query(input logic [31:0] xq, input logic [31:0] yq);
        grid_item_t it;
        it.func        = FUNC_QUERY;
        it.x_pos       = xq;
        it.y_pos       = yq;
        it.write_col   = 8'($urandom);
        it.write_row   = 8'($urandom);
        it.write_value = $urandom;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic write_block(input int bx, input int by);
        int x1;
        int y1;
        x1 = (bx + 1) % GRID;
        y1 = (by + 1) % GRID;
        push_write(8'(bx), 8'(by), rand_sample());
        push_write(8'(x1), 8'(by), rand_sample());
        push_write(8'(bx), 8'(y1), rand_sample());
        push_write(8'(x1), 8'(y1), rand_sample());
        block_origins.insert(block_origins.size(), {8'(bx), 8'(by)});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                accept_item(cur_item);
            if (!item_valid || !item_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    cur_item = pending_items.pop_front();
                    func        <= cur_item.func;
                    x_pos       <= cur_item.x_pos;
                    y_pos       <= cur_item.y_pos;
                    write_col   <= cur_item.write_col;
                    write_row   <= cur_item.write_row;
                    write_value <= cur_item.write_value;
                    item_valid  <= 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        send_steady = !send_steady;
                    send_gap = send_steady ? 0 : $urandom_range(0, 15);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left = 0;
        end
        else if (result_valid && !result_stall)
        begin
            if (expected_values.size() == 0)
            begin
                $error("value: unexpected item, expected none, actual %h", value);
                error_count++;
            end
            else if (value !== expected_values[0])
            begin
                $error("value: expected %h, actual %h", expected_values[0], value);
                error_count++;
            end
            if (expected_values.size() != 0)
                void'(expected_values.pop_front());
            if ($urandom_range(0, 31) == 0)
                recv_steady = !recv_steady;
            hold_left = recv_steady ? 0 : $urandom_range(0, 15);
            result_stall <= (hold_left != 0);
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= (hold_left != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int          sel;
        int          bx;
        int          by;
        int          nq;
        logic [15:0] pick;

        // wrap corner block, its neighbours and extreme samples
        push_write(8'd255, 8'd255, 32'h7FFF_FFFF);
        push_write(8'd0,   8'd255, 32'h8000_0000);
        push_write(8'd255, 8'd0,   32'h0000_0000);
        push_write(8'd0,   8'd0,   32'hFFFF_FFFF);
        push_write(8'd1,   8'd0,   32'h7FFF_FFFF);
        push_write(8'd0,   8'd1,   32'h8000_0000);
        push_write(8'd1,   8'd1,   32'h1234_5678);
        push_write(8'd255, 8'd1,   32'h7FFF_FFFF);
        push_write(8'd1,   8'd255, 32'h8000_0000);
        block_origins.insert(block_origins.size(), {8'd255, 8'd255});
        block_origins.insert(block_origins.size(), {8'd0, 8'd0});
        block_origins.insert(block_origins.size(), {8'd255, 8'd0});
        block_origins.insert(block_origins.size(), {8'd0, 8'd255});
        push_query(32'h00FF_0000, 32'h00FF_0000);
        push_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_query(32'h7FFF_FFFF, 32'h8000_0000);
        push_query(32'hFF00_0000, 32'h0000_8000);
        push_query(32'h8000_0000, 32'h7FFF_FFFF);
        push_write(8'd255, 8'd255, 32'h8000_0000);
        push_write(8'd0,   8'd255, 32'h8000_0000);
        push_write(8'd255, 8'd0,   32'h8000_0000);
        push_write(8'd0,   8'd0,   32'h8000_0000);
        push_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_query(32'h00FF_8000, 32'h00FF_0001);

        while (pending_items.size() < 920)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
            begin
                bx = $urandom_range(0, GRID - 1);
                by = $urandom_range(0, GRID - 1);
                write_block(bx, by);
                nq = $urandom_range(1, 3);
                repeat (nq)
                    push_query(coord_for(bx), coord_for(by));
            end
            else if (sel < 9)
            begin
                pick = block_origins[$urandom_range(0, block_origins.size() - 1)];
                push_query(coord_for(pick[15:8]), coord_for(pick[7:0]));
            end
            else
                push_write(8'($urandom), 8'($urandom), rand_sample());
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() != 0 || item_valid)
            @(posedge clk);
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES + 4) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[periodic_bilinear_interpolator_top.f]
design/pbi_pkg.sv
design/pbi_ram.sv
design/pbi_wrap.sv
design/pbi_blend.sv
design/periodic_bilinear_interpolator_top.sv
tb/tb_top.sv
